// File: rtl/oboc_pkg.sv
package oboc_pkg;

	localparam int FRAC_BITS = 8;
	localparam int CORDIC_STAGES = 16;
	localparam int CORDIC_FRAC = 30;
	localparam int TRIG_FRAC = 16;

	localparam int CW = 33;
	localparam int AW = 34;
	localparam int STAGE_W = 5;
	localparam int TRIG_W = 19;
	localparam int DIM_W = 15;
	localparam int POS_W = 16;
	localparam int PROD_W = TRIG_W + DIM_W + 1;
	localparam int SUM_W = PROD_W + 2;
	localparam int CORNER_W = 18;
	localparam int PXW = 18;
	localparam int PIX_W = 14;
	localparam int LIM_W = 13;
	localparam int IDX_W = 3;

	localparam logic [CW-1:0] CORDIC_GAIN = CW'(652032874);

	localparam int PADDR_W = 5;
	localparam logic [2:0] REG_COL_OFFSET = 3'd0;
	localparam logic [2:0] REG_ROW_OFFSET = 3'd1;
	localparam logic [2:0] REG_COL_SCALE = 3'd2;
	localparam logic [2:0] REG_ROW_SCALE = 3'd3;
	localparam logic [2:0] REG_COL_LIMIT = 3'd4;
	localparam logic [2:0] REG_ROW_LIMIT = 3'd5;

	localparam logic [7:0] RST_COL_OFFSET = 8'd15;
	localparam logic [7:0] RST_ROW_OFFSET = 8'd60;
	localparam logic [6:0] RST_COL_SCALE = 7'd15;
	localparam logic [6:0] RST_ROW_SCALE = 7'h76;
	localparam logic [LIM_W-1:0] RST_COL_LIMIT = LIM_W'(450);
	localparam logic [LIM_W-1:0] RST_ROW_LIMIT = LIM_W'(600);

	localparam logic [IDX_W-1:0] LAST_CORNER = 3'd7;
	localparam logic [IDX_W-1:0] VIS_CORNER_A = 3'd4;
	localparam logic [IDX_W-1:0] VIS_CORNER_B = 3'd5;

	typedef struct packed {
		logic [DIM_W-1:0] h;
		logic [DIM_W-1:0] l;
		logic [DIM_W-1:0] w;
		logic signed [POS_W-1:0] cx;
		logic signed [POS_W-1:0] cy;
		logic signed [POS_W-1:0] cz;
		logic flip;
	} box_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [AW-1:0] z;
		box_t box;
	} cord_t;

	typedef struct packed {
		logic signed [PROD_W-1:0] cw;
		logic signed [PROD_W-1:0] sl;
		logic signed [PROD_W-1:0] sw;
		logic signed [PROD_W-1:0] cl;
		logic [DIM_W-1:0] h;
		logic signed [POS_W-1:0] cx;
		logic signed [POS_W-1:0] cy;
		logic signed [POS_W-1:0] cz;
		logic flip;
	} prod_t;

	typedef struct packed {
		logic signed [7:0] col_offset;
		logic signed [7:0] row_offset;
		logic signed [6:0] col_scale;
		logic signed [6:0] row_scale;
		logic [LIM_W-1:0] col_limit;
		logic [LIM_W-1:0] row_limit;
	} cfg_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic signed [CORNER_W-1:0] x;
		logic signed [CORNER_W-1:0] y;
		logic signed [CORNER_W-1:0] z;
		logic signed [PIX_W-1:0] col;
		logic signed [PIX_W-1:0] row;
		logic in_view;
		logic visible;
		logic last;
	} corner_t;

	function automatic logic [AW-1:0] atan_angle(input logic [STAGE_W-1:0] i);
		logic [AW-1:0] a;
		case (i)
			5'd0: a = AW'(536870912);
			5'd1: a = AW'(316933406);
			5'd2: a = AW'(167458907);
			5'd3: a = AW'(85004756);
			5'd4: a = AW'(42667331);
			5'd5: a = AW'(21354465);
			5'd6: a = AW'(10679838);
			5'd7: a = AW'(5340245);
			5'd8: a = AW'(2670163);
			5'd9: a = AW'(1335087);
			5'd10: a = AW'(667544);
			5'd11: a = AW'(333772);
			5'd12: a = AW'(166886);
			5'd13: a = AW'(83443);
			5'd14: a = AW'(41722);
			5'd15: a = AW'(20861);
			5'd16: a = AW'(10430);
			5'd17: a = AW'(5215);
			5'd18: a = AW'(2608);
			5'd19: a = AW'(1304);
			5'd20: a = AW'(652);
			5'd21: a = AW'(326);
			5'd22: a = AW'(163);
			5'd23: a = AW'(81);
			default: a = '0;
		endcase
		return a;
	endfunction

	function automatic logic [CORNER_W-1:0] sat_corner(input logic [SUM_W-1:0] v);
		logic [CORNER_W-1:0] r;
		if (&v[SUM_W-1:CORNER_W-1] || ~|v[SUM_W-1:CORNER_W-1])
			r = v[CORNER_W-1:0];
		else if (v[SUM_W-1])
			r = {1'b1, {(CORNER_W-1){1'b0}}};
		else
			r = {1'b0, {(CORNER_W-1){1'b1}}};
		return r;
	endfunction

	function automatic logic [PIX_W-1:0] sat_pixel(input logic [PXW-1:0] v);
		logic [PIX_W-1:0] r;
		if (&v[PXW-1:PIX_W-1] || ~|v[PXW-1:PIX_W-1])
			r = v[PIX_W-1:0];
		else if (v[PXW-1])
			r = {1'b1, {(PIX_W-1){1'b0}}};
		else
			r = {1'b0, {(PIX_W-1){1'b1}}};
		return r;
	endfunction

endpackage

// File: rtl/oriented_box_corner_projector.sv
// Oriented box corner projector.
// Input stream (s_*): one transfer per box with its size, bottom-face center
// and yaw. Output stream (m_*): eight transfers per box, one per corner, in
// fixed corner order; tlast marks the eighth, tuser carries the corner index.
// Each corner carries its rotated position, its bird's-eye pixel, an in-view
// flag and, on the last corner, the box visibility flag.
// Sine and cosine come from a row of 16 CORDIC cells, one rotation step per
// cell; a product stage and a five-register corner pipeline follow.
// The corner sequencer issues one corner per cycle while the pipeline is not
// stalled, and takes the next box only as it issues the eighth corner of the
// current one; boxes queue in the cell row meanwhile.
// The APB port sets the pixel offsets, scales and limits; write it only
// while no box is in flight. pready is always high.
// Reset clears every valid flag and loads the register defaults.
// When m_tready is low, corners hold in the pipeline; s_tready drops once
// every stage is full.
module oriented_box_corner_projector (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// h[14:0] l[29:15] w[44:30] cx[60:45] cy[76:61] cz[92:77] yaw[108:93]
	input  logic [111:0]                 s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// x[17:0] y[35:18] z[53:36] col[67:54] row[81:68] in_view[82] visible[83]
	output logic [87:0]                  m_tdata,
	// corner_index[2:0]
	output logic [2:0]                   m_tuser,
	output logic                         m_tlast,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [oboc_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import oboc_pkg::*;

	cfg_t cfg_q;
	logic wr_en;
	logic [2:0] reg_idx;

	cord_t chain [0:CORDIC_STAGES];
	logic vld [0:CORDIC_STAGES];
	logic rdy [0:CORDIC_STAGES];

	logic flip;
	logic [POS_W-1:0] yaw;
	logic [POS_W-1:0] yaw_a;

	logic p_vld, p_rdy;
	prod_t p_data;
	corner_t crn;

	assign pready = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.col_offset <= RST_COL_OFFSET;
			cfg_q.row_offset <= RST_ROW_OFFSET;
			cfg_q.col_scale <= RST_COL_SCALE;
			cfg_q.row_scale <= RST_ROW_SCALE;
			cfg_q.col_limit <= RST_COL_LIMIT;
			cfg_q.row_limit <= RST_ROW_LIMIT;
		end else if (wr_en) begin
			case (reg_idx)
				REG_COL_OFFSET: cfg_q.col_offset <= pwdata[7:0];
				REG_ROW_OFFSET: cfg_q.row_offset <= pwdata[7:0];
				REG_COL_SCALE: cfg_q.col_scale <= pwdata[6:0];
				REG_ROW_SCALE: cfg_q.row_scale <= pwdata[6:0];
				REG_COL_LIMIT: cfg_q.col_limit <= pwdata[LIM_W-1:0];
				REG_ROW_LIMIT: cfg_q.row_limit <= pwdata[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_COL_OFFSET: prdata = {{24{cfg_q.col_offset[7]}}, cfg_q.col_offset};
			REG_ROW_OFFSET: prdata = {{24{cfg_q.row_offset[7]}}, cfg_q.row_offset};
			REG_COL_SCALE: prdata = {{25{cfg_q.col_scale[6]}}, cfg_q.col_scale};
			REG_ROW_SCALE: prdata = {{25{cfg_q.row_scale[6]}}, cfg_q.row_scale};
			REG_COL_LIMIT: prdata = {{(32-LIM_W){1'b0}}, cfg_q.col_limit};
			REG_ROW_LIMIT: prdata = {{(32-LIM_W){1'b0}}, cfg_q.row_limit};
			default: prdata = '0;
		endcase
	end

	// fold the yaw into the right half-plane, negate sine and cosine later
	always_comb begin
		yaw = s_tdata[108:93];
		flip = yaw[15] ^ yaw[14];
		yaw_a = {yaw[15] ^ flip, yaw[14:0]};
		chain[0].x = CORDIC_GAIN;
		chain[0].y = '0;
		chain[0].z = {{(AW-POS_W-16){yaw_a[POS_W-1]}}, yaw_a, 16'b0};
		chain[0].box.h = s_tdata[14:0];
		chain[0].box.l = s_tdata[29:15];
		chain[0].box.w = s_tdata[44:30];
		chain[0].box.cx = s_tdata[60:45];
		chain[0].box.cy = s_tdata[76:61];
		chain[0].box.cz = s_tdata[92:77];
		chain[0].box.flip = flip;
	end

	assign vld[0] = s_tvalid;
	assign s_tready = rdy[0];

	genvar i;
	generate
		for (i = 0; i < CORDIC_STAGES; i++) begin : g_cell
			oboc_cordic_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.stage     (STAGE_W'(i)),
				.in_valid  (vld[i]),
				.in_ready  (rdy[i]),
				.in_data   (chain[i]),
				.out_valid (vld[i+1]),
				.out_ready (rdy[i+1]),
				.out_data  (chain[i+1])
			);
		end
	endgenerate

	oboc_product u_product (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld[CORDIC_STAGES]),
		.in_ready  (rdy[CORDIC_STAGES]),
		.in_data   (chain[CORDIC_STAGES]),
		.out_valid (p_vld),
		.out_ready (p_rdy),
		.out_data  (p_data)
	);

	oboc_corner u_corner (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (p_vld),
		.in_ready  (p_rdy),
		.in_data   (p_data),
		.cfg       (cfg_q),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (crn)
	);

	assign m_tdata = {4'b0, crn.visible, crn.in_view, crn.row, crn.col, crn.z, crn.y, crn.x};
	assign m_tuser = crn.idx;
	assign m_tlast = crn.last;

endmodule

// File: rtl/oboc_cordic_cell.sv
module oboc_cordic_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [oboc_pkg::STAGE_W-1:0] stage,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  oboc_pkg::cord_t              in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output oboc_pkg::cord_t              out_data
);
	import oboc_pkg::*;

	logic v_q;
	cord_t d_q;
	cord_t nxt;
	logic signed [CW-1:0] x_sh;
	logic signed [CW-1:0] y_sh;
	logic [AW-1:0] ang;

	assign in_ready = !v_q || out_ready;
	assign out_valid = v_q;
	assign out_data = d_q;

	always_comb begin
		x_sh = $signed(in_data.x) >>> stage;
		y_sh = $signed(in_data.y) >>> stage;
		ang = atan_angle(stage);
		nxt = in_data;
		if (!in_data.z[AW-1]) begin
			nxt.x = in_data.x - y_sh;
			nxt.y = in_data.y + x_sh;
			nxt.z = in_data.z - $signed(ang);
		end else begin
			nxt.x = in_data.x + y_sh;
			nxt.y = in_data.y - x_sh;
			nxt.z = in_data.z + $signed(ang);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= 1'b0;
		else if (in_ready)
			v_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			d_q <= nxt;
	end

endmodule

// File: rtl/oboc_product.sv
module oboc_product (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  oboc_pkg::cord_t in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output oboc_pkg::prod_t out_data
);
	import oboc_pkg::*;

	localparam int TRIG_SHIFT = CORDIC_FRAC - TRIG_FRAC;
	localparam logic signed [CW-1:0] TRIG_HALF = CW'(1) << (TRIG_SHIFT - 1);

	logic v_q;
	prod_t d_q;
	prod_t nxt;
	logic signed [CW-1:0] xr;
	logic signed [CW-1:0] yr;
	logic signed [TRIG_W-1:0] cs;
	logic signed [TRIG_W-1:0] sn;
	logic signed [DIM_W:0] w_s;
	logic signed [DIM_W:0] l_s;

	assign in_ready = !v_q || out_ready;
	assign out_valid = v_q;
	assign out_data = d_q;

	always_comb begin
		xr = (in_data.x + TRIG_HALF) >>> TRIG_SHIFT;
		yr = (in_data.y + TRIG_HALF) >>> TRIG_SHIFT;
		cs = xr[TRIG_W-1:0];
		sn = yr[TRIG_W-1:0];
		w_s = $signed({1'b0, in_data.box.w});
		l_s = $signed({1'b0, in_data.box.l});
		nxt.cw = cs * w_s;
		nxt.sl = sn * l_s;
		nxt.sw = sn * w_s;
		nxt.cl = cs * l_s;
		nxt.h = in_data.box.h;
		nxt.cx = in_data.box.cx;
		nxt.cy = in_data.box.cy;
		nxt.cz = in_data.box.cz;
		nxt.flip = in_data.box.flip;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= 1'b0;
		else if (in_ready)
			v_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			d_q <= nxt;
	end

endmodule

// File: rtl/oboc_corner.sv
module oboc_corner (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  oboc_pkg::prod_t   in_data,
	input  oboc_pkg::cfg_t    cfg,
	output logic              out_valid,
	input  logic              out_ready,
	output oboc_pkg::corner_t out_data
);
	import oboc_pkg::*;

	localparam logic signed [SUM_W-1:0] SUM_HALF = SUM_W'(1) << TRIG_FRAC;
	localparam logic signed [PXW-1:0] TRUNC_BIAS = PXW'((1 << FRAC_BITS) - 1);

	// corner sequencer
	prod_t gen_q;
	logic gen_v_q;
	logic [IDX_W-1:0] k_q;
	logic gen_fire;

	// rotated sums
	logic a_v_q;
	logic [IDX_W-1:0] a_k_q;
	logic signed [SUM_W-1:0] a_sx_q;
	logic signed [SUM_W-1:0] a_sz_q;
	logic signed [CORNER_W-1:0] a_y_q;
	logic signed [POS_W-1:0] a_cx_q;
	logic signed [POS_W-1:0] a_cz_q;

	// corner position
	logic b_v_q;
	logic [IDX_W-1:0] b_k_q;
	logic signed [CORNER_W-1:0] b_x_q;
	logic signed [CORNER_W-1:0] b_y_q;
	logic signed [CORNER_W-1:0] b_z_q;

	// pixel
	logic c_v_q;
	logic [IDX_W-1:0] c_k_q;
	logic signed [CORNER_W-1:0] c_x_q;
	logic signed [CORNER_W-1:0] c_y_q;
	logic signed [CORNER_W-1:0] c_z_q;
	logic signed [PIX_W-1:0] c_col_q;
	logic signed [PIX_W-1:0] c_row_q;

	logic o_v_q;
	corner_t o_q;
	logic v4_q;
	logic v5_q;

	logic a_rdy, b_rdy, c_rdy, o_rdy;

	logic xn, zn;
	logic signed [SUM_W-1:0] e_cw, e_sl, e_sw, e_cl;
	logic signed [SUM_W-1:0] sx_n, sz_n;
	logic signed [CORNER_W-1:0] cy_e, h_e, y_n;
	logic signed [SUM_W-1:0] xw_n, zw_n;
	logic signed [PXW-1:0] bx_e, bz_e, tx, tz;
	logic signed [PXW-1:0] ofs_c, ofs_r, scl_c, scl_r, col_pre, row_pre, col_m, row_m;
	logic view_n;

	assign o_rdy = !o_v_q || out_ready;
	assign c_rdy = !c_v_q || o_rdy;
	assign b_rdy = !b_v_q || c_rdy;
	assign a_rdy = !a_v_q || b_rdy;
	assign gen_fire = gen_v_q && a_rdy;
	assign in_ready = !gen_v_q || (a_rdy && k_q == LAST_CORNER);

	assign out_valid = o_v_q;
	assign out_data = o_q;

	always_comb begin
		xn = (k_q[0] ^ k_q[1]) ^ gen_q.flip;
		zn = !k_q[1] ^ gen_q.flip;
		e_cw = gen_q.cw;
		e_sl = gen_q.sl;
		e_sw = gen_q.sw;
		e_cl = gen_q.cl;
		sx_n = (xn ? -e_cw : e_cw) + (zn ? -e_sl : e_sl) + SUM_HALF;
		sz_n = (xn ? e_sw : -e_sw) + (zn ? -e_cl : e_cl) + SUM_HALF;
		cy_e = gen_q.cy;
		h_e = $signed({{(CORNER_W-DIM_W){1'b0}}, gen_q.h});
		y_n = k_q[2] ? cy_e - h_e : cy_e;
	end

	always_comb begin
		xw_n = (a_sx_q >>> (TRIG_FRAC + 1)) + a_cx_q;
		zw_n = (a_sz_q >>> (TRIG_FRAC + 1)) + a_cz_q;
	end

	always_comb begin
		bx_e = b_x_q;
		bz_e = b_z_q;
		tx = (bx_e + (bx_e[PXW-1] ? TRUNC_BIAS : PXW'(0))) >>> FRAC_BITS;
		tz = (bz_e + (bz_e[PXW-1] ? TRUNC_BIAS : PXW'(0))) >>> FRAC_BITS;
		ofs_c = cfg.col_offset;
		ofs_r = cfg.row_offset;
		scl_c = cfg.col_scale;
		scl_r = cfg.row_scale;
		col_pre = tx + ofs_c;
		row_pre = tz - ofs_r;
		col_m = col_pre * scl_c;
		row_m = row_pre * scl_r;
	end

	assign view_n = !c_col_q[PIX_W-1] && (c_col_q != '0)
		&& (c_col_q[LIM_W-1:0] < cfg.col_limit)
		&& !c_row_q[PIX_W-1] && (c_row_q != '0)
		&& (c_row_q[LIM_W-1:0] < cfg.row_limit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_v_q <= 1'b0;
			k_q <= '0;
		end else if (in_valid && in_ready) begin
			gen_v_q <= 1'b1;
			k_q <= '0;
		end else if (gen_fire) begin
			k_q <= k_q + 1'b1;
			if (k_q == LAST_CORNER)
				gen_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			gen_q <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_v_q <= 1'b0;
			b_v_q <= 1'b0;
			c_v_q <= 1'b0;
			o_v_q <= 1'b0;
			v4_q <= 1'b0;
			v5_q <= 1'b0;
		end else begin
			if (a_rdy)
				a_v_q <= gen_v_q;
			if (b_rdy)
				b_v_q <= a_v_q;
			if (c_rdy)
				c_v_q <= b_v_q;
			if (o_rdy)
				o_v_q <= c_v_q;
			if (o_rdy && c_v_q && c_k_q == VIS_CORNER_A)
				v4_q <= view_n;
			if (o_rdy && c_v_q && c_k_q == VIS_CORNER_B)
				v5_q <= view_n;
		end
	end

	always_ff @(posedge clk) begin
		if (gen_fire) begin
			a_k_q <= k_q;
			a_sx_q <= sx_n;
			a_sz_q <= sz_n;
			a_y_q <= y_n;
			a_cx_q <= gen_q.cx;
			a_cz_q <= gen_q.cz;
		end
		if (b_rdy && a_v_q) begin
			b_k_q <= a_k_q;
			b_x_q <= sat_corner(xw_n);
			b_y_q <= a_y_q;
			b_z_q <= sat_corner(zw_n);
		end
		if (c_rdy && b_v_q) begin
			c_k_q <= b_k_q;
			c_x_q <= b_x_q;
			c_y_q <= b_y_q;
			c_z_q <= b_z_q;
			c_col_q <= sat_pixel(col_m);
			c_row_q <= sat_pixel(row_m);
		end
		if (o_rdy && c_v_q) begin
			o_q.idx <= c_k_q;
			o_q.x <= c_x_q;
			o_q.y <= c_y_q;
			o_q.z <= c_z_q;
			o_q.col <= c_col_q;
			o_q.row <= c_row_q;
			o_q.in_view <= view_n;
			o_q.visible <= (c_k_q == LAST_CORNER) && v4_q && v5_q;
			o_q.last <= (c_k_q == LAST_CORNER);
		end
	end

endmodule
